>>> rtl/nlc_pkg.sv
// types, constants and character helpers for the number literal classifier
`default_nettype none
package nlc_pkg;

   typedef enum logic [1:0] {
      KIND_DEC   = 2'd0,
      KIND_HEX   = 2'd1,
      KIND_OCT   = 2'd2,
      KIND_RADIX = 2'd3
   } kind_type;

   localparam logic [6:0] BASE_SAT = 7'd100;
   localparam logic [6:0] BASE_MAX = 7'd36;
   localparam logic [6:0] BASE_MIN = 7'd2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_LO_E  = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_LO_R  = 8'h72;
   localparam logic [7:0] CH_UP_R  = 8'h52;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_UP_N  = 8'h4e;
   localparam logic [7:0] CH_UP_M  = 8'h4d;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_Z  = 8'h7a;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;

   typedef struct packed {
      kind_type   kind;
      logic       digits_present;
      logic       dot_seen;
      logic       slash_seen;
      logic       exp_seen;
      logic       eight_or_nine_seen;
      logic       zero_led;
      logic       token_ok;
      logic       lead_digit_done;
      logic [6:0] base_accum;
      logic       may_take_x;
      logic       may_take_sign;
      logic       suffix_taken;
   } state_type;

   localparam state_type STATE_RESET = '{
      kind:               KIND_DEC,
      digits_present:     1'b0,
      dot_seen:           1'b0,
      slash_seen:         1'b0,
      exp_seen:           1'b0,
      eight_or_nine_seen: 1'b0,
      zero_led:           1'b0,
      token_ok:           1'b1,
      lead_digit_done:    1'b0,
      base_accum:         7'd0,
      may_take_x:         1'b0,
      may_take_sign:      1'b0,
      suffix_taken:       1'b0
   };

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= CH_LO_A) && (c <= CH_LO_Z);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CH_UP_A) && (c <= CH_UP_Z);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
             ((c >= CH_UP_A) && (c <= CH_UP_F));
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_dec(c) || is_lower(c) || is_upper(c);
   endfunction

   // digit value 0..35, only meaningful for alphanumeric codes
   function automatic logic [5:0] char_value(input logic [7:0] c);
      logic [7:0] v;
      if (is_dec(c)) begin
         v = c - CH_ZERO;
      end else if (is_lower(c)) begin
         v = c - CH_LO_A + 8'd10;
      end else begin
         v = c - CH_UP_A + 8'd10;
      end
      return v[5:0];
   endfunction

   // first digit of the token
   function automatic state_type lead_digit(input state_type s, input logic [7:0] c);
      state_type r;
      r = s;
      r.digits_present  = 1'b1;
      r.base_accum      = {3'b000, c[3:0]};
      r.lead_digit_done = 1'b1;
      if (c == CH_ZERO) begin
         r.zero_led   = 1'b1;
         r.kind       = KIND_OCT;
         r.may_take_x = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/number_literal_classifier.sv
// number literal classifier top level: per-character state update and verdict register
//
// req channel: one beat per token character (req_ch), with req_starts_token on the
// first character (a digit or a sign) and a closing beat with req_token_end set that
// carries no character. Only the closing beat produces a result.
// rsp channel: one beat per closing beat, rsp_verdict 0 for a valid number and 1
// for an erroneous one.
// Verdict timing: registered, shown in the cycle after the closing beat is accepted.
// Throughput: one beat per cycle while req_ready is high; the character state update
// is a single level of flag and small-counter logic feeding the state registers.
// Stall: character beats keep flowing while a verdict waits in the output
// register; only a closing beat is held off (req_ready low) while the receiver
// has not taken the previous verdict.
// Reset: synchronous, active high; the token state returns to its idle values and
// the output register is emptied. The block accepts beats as soon as reset
// is released.
`default_nettype none
module number_literal_classifier (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_starts_token,
   input  wire logic       req_token_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_verdict
);

   nlc_pkg::state_type st_ff, st_in, body_st;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_verdict_ff, rsp_verdict_in;
   logic req_fire;
   logic bad_octal, good;
   logic skip;
   logic [9:0] accum_wide;

   assign req_ready   = !rsp_valid_ff || rsp_ready || !req_token_end;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   assign bad_octal = (st_ff.kind == nlc_pkg::KIND_OCT) && st_ff.zero_led &&
                      st_ff.eight_or_nine_seen && !st_ff.dot_seen &&
                      !st_ff.slash_seen && !st_ff.exp_seen;
   assign good = st_ff.token_ok && st_ff.digits_present && !bad_octal;

   assign accum_wide = {3'b000, st_ff.base_accum} * 10'd10 + {6'b0, req_ch[3:0]};

   // body character on top of the current state
   always_comb begin
      body_st = st_ff;
      if (st_ff.kind == nlc_pkg::KIND_HEX) begin
         if (nlc_pkg::is_hex(req_ch)) body_st.digits_present = 1'b1;
         else                         body_st.token_ok = 1'b0;
      end else if (st_ff.kind == nlc_pkg::KIND_RADIX) begin
         if (nlc_pkg::is_alnum(req_ch) &&
             ({1'b0, nlc_pkg::char_value(req_ch)} < st_ff.base_accum)) begin
            body_st.digits_present = 1'b1;
         end else begin
            body_st.token_ok = 1'b0;
         end
      end else if (nlc_pkg::is_dec(req_ch)) begin
         if (!st_ff.lead_digit_done) begin
            body_st = nlc_pkg::lead_digit(st_ff, req_ch);
         end else begin
            body_st.digits_present = 1'b1;
            if (req_ch == nlc_pkg::CH_EIGHT || req_ch == nlc_pkg::CH_NINE) begin
               body_st.eight_or_nine_seen = 1'b1;
            end
            if (st_ff.base_accum < nlc_pkg::BASE_SAT) begin
               if (accum_wide > {3'b000, nlc_pkg::BASE_SAT}) begin
                  body_st.base_accum = nlc_pkg::BASE_SAT;
               end else begin
                  body_st.base_accum = accum_wide[6:0];
               end
            end
         end
      end else if (req_ch == nlc_pkg::CH_DOT) begin
         if (!st_ff.dot_seen && !st_ff.slash_seen && !st_ff.exp_seen) begin
            body_st.dot_seen = 1'b1;
            body_st.kind     = nlc_pkg::KIND_DEC;
         end else begin
            body_st.token_ok = 1'b0;
         end
      end else if (req_ch == nlc_pkg::CH_SLASH) begin
         if (!st_ff.dot_seen && !st_ff.slash_seen && !st_ff.exp_seen &&
             st_ff.digits_present) begin
            body_st.slash_seen     = 1'b1;
            body_st.digits_present = 1'b0;
            body_st.kind           = nlc_pkg::KIND_DEC;
         end else begin
            body_st.token_ok = 1'b0;
         end
      end else if (req_ch == nlc_pkg::CH_LO_E || req_ch == nlc_pkg::CH_UP_E) begin
         if (!st_ff.exp_seen && !st_ff.slash_seen && st_ff.digits_present) begin
            body_st.exp_seen       = 1'b1;
            body_st.digits_present = 1'b0;
            body_st.kind           = nlc_pkg::KIND_DEC;
            body_st.may_take_sign  = 1'b1;
         end else begin
            body_st.token_ok = 1'b0;
         end
      end else if (req_ch == nlc_pkg::CH_LO_R || req_ch == nlc_pkg::CH_UP_R) begin
         if (!st_ff.dot_seen && !st_ff.slash_seen && !st_ff.exp_seen &&
             st_ff.digits_present && st_ff.base_accum >= nlc_pkg::BASE_MIN &&
             st_ff.base_accum <= nlc_pkg::BASE_MAX) begin
            body_st.kind           = nlc_pkg::KIND_RADIX;
            body_st.digits_present = 1'b0;
         end else begin
            body_st.token_ok = 1'b0;
         end
      end else if (req_ch == nlc_pkg::CH_UP_N) begin
         if (st_ff.dot_seen || st_ff.exp_seen || st_ff.slash_seen ||
             !st_ff.digits_present) begin
            body_st.token_ok = 1'b0;
         end
         body_st.suffix_taken = 1'b1;
      end else if (req_ch == nlc_pkg::CH_UP_M) begin
         if (st_ff.slash_seen || !st_ff.digits_present) body_st.token_ok = 1'b0;
         body_st.suffix_taken = 1'b1;
      end else begin
         body_st.token_ok = 1'b0;
      end
   end

   // token state next value
   always_comb begin
      st_in = st_ff;
      skip  = 1'b0;
      if (req_fire) begin
         if (req_token_end) begin
            st_in = nlc_pkg::STATE_RESET;
         end else if (req_starts_token) begin
            st_in = nlc_pkg::STATE_RESET;
            if (nlc_pkg::is_dec(req_ch)) begin
               st_in = nlc_pkg::lead_digit(nlc_pkg::STATE_RESET, req_ch);
            end
         end else if (!st_ff.token_ok) begin
            st_in = st_ff;
         end else if (st_ff.suffix_taken) begin
            st_in.token_ok = 1'b0;
         end else begin
            if (st_ff.may_take_x &&
                (req_ch == nlc_pkg::CH_LO_X || req_ch == nlc_pkg::CH_UP_X)) begin
               skip                 = 1'b1;
               st_in.may_take_x     = 1'b0;
               st_in.kind           = nlc_pkg::KIND_HEX;
               st_in.digits_present = 1'b0;
            end else if (st_ff.may_take_sign &&
                         (req_ch == nlc_pkg::CH_PLUS || req_ch == nlc_pkg::CH_MINUS)) begin
               skip                = 1'b1;
               st_in.may_take_sign = 1'b0;
            end
            if (!skip) begin
               st_in               = body_st;
               // the prefix windows close on any character, body may reopen either
               st_in.may_take_x    = body_st.may_take_x && !st_ff.may_take_x;
               st_in.may_take_sign = body_st.may_take_sign && !st_ff.may_take_sign;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      if (req_fire && req_token_end) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = !good;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= nlc_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_verdict_ff <= rsp_verdict_in;
   end

endmodule
`default_nettype wire

>>> rtl/nlc_checker.sv
// port-level checker for the number literal classifier and its bind
`default_nettype none
module nlc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_ch,
   input wire logic       req_starts_token,
   input wire logic       req_token_end,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_verdict
);

   logic req_fire;
   logic nonzero_digit;

   assign req_fire      = req_valid && req_ready;
   assign nonzero_digit = (req_ch >= 8'h31) && (req_ch <= 8'h39);

   // a stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict))
      else $error("verdict changed or dropped while stalled");

   // every closing beat shows a verdict next cycle
   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_token_end |=> rsp_valid)
      else $error("closing beat produced no verdict");

   // a waiting verdict is never overwritten by another closing beat
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && req_token_end |-> !req_ready)
      else $error("closing beat accepted over a waiting verdict");

   // a single nonzero digit token is a valid number
   a_single_digit: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_token_end && req_starts_token && nonzero_digit)
      ##1 (req_fire && req_token_end) |=> rsp_valid && !rsp_verdict)
      else $error("single digit token reported erroneous");

endmodule

bind number_literal_classifier nlc_checker u_nlc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_ch           (req_ch),
   .req_starts_token (req_starts_token),
   .req_token_end    (req_token_end),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_verdict      (rsp_verdict)
);
`default_nettype wire
